>>> sv/lras_pkg.sv
// Shared types and constants for the line rasterizer.
// Item structs, coordinate/error types and operation codes.
// No dependencies.
package lras_pkg;

    localparam int COORD_BITS = 10;
    localparam int INC_BITS   = COORD_BITS + 2;
    localparam int ERR_BITS   = COORD_BITS + 3;

    typedef logic [COORD_BITS-1:0]      t_coord;
    typedef logic [INC_BITS-1:0]        t_inc;
    typedef logic signed [ERR_BITS-1:0] t_err;
    typedef logic signed [COORD_BITS:0] t_delta;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } t_op;

    typedef struct packed {
        t_op    operation;
        t_coord start_x;
        t_coord start_y;
        t_coord end_x;
        t_coord end_y;
    } t_in_item;

    typedef struct packed {
        logic   pixel_valid;
        t_coord pixel_x;
        t_coord pixel_y;
        logic   last_pixel;
    } t_out_item;

endpackage

>>> sv/lras_walker.sv
// Line walker: holds the Bresenham state and computes one result per item.
// Setup on load and one pixel step per step item while a line is active, both combinational.
// Depends on lras_pkg.
module lras_walker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  lras_pkg::t_in_item  i_item,
    output lras_pkg::t_out_item o_result
);

    lras_pkg::t_coord r_cur_x, n_cur_x;
    lras_pkg::t_coord r_cur_y, n_cur_y;
    lras_pkg::t_coord r_major_stop, n_major_stop;
    lras_pkg::t_err   r_error, n_error;
    lras_pkg::t_inc   r_straight_inc, n_straight_inc;
    lras_pkg::t_err   r_diag_inc, n_diag_inc;
    logic             r_minor_up, n_minor_up;
    logic             r_steep, n_steep;
    logic             r_active, n_active;

    // load setup
    lras_pkg::t_delta dx, dy;
    lras_pkg::t_coord adx, ady, maj_len, min_len;
    logic             shallow, from_a;
    // step
    logic             go_straight, err_le_zero;
    lras_pkg::t_coord major_now;

    always_comb begin
        dx = $signed({1'b0, i_item.end_x}) - $signed({1'b0, i_item.start_x});
        dy = $signed({1'b0, i_item.end_y}) - $signed({1'b0, i_item.start_y});
        adx = dx[lras_pkg::COORD_BITS] ? lras_pkg::t_coord'(-dx)
                                       : dx[lras_pkg::COORD_BITS-1:0];
        ady = dy[lras_pkg::COORD_BITS] ? lras_pkg::t_coord'(-dy)
                                       : dy[lras_pkg::COORD_BITS-1:0];
        shallow = (ady <= adx);
        maj_len = shallow ? adx : ady;
        min_len = shallow ? ady : adx;
        from_a  = shallow ? !dx[lras_pkg::COORD_BITS] : !dy[lras_pkg::COORD_BITS];

        err_le_zero = r_error[lras_pkg::ERR_BITS-1] || (r_error == '0);
        go_straight = r_steep ? err_le_zero : r_error[lras_pkg::ERR_BITS-1];

        n_cur_x        = r_cur_x;
        n_cur_y        = r_cur_y;
        n_major_stop   = r_major_stop;
        n_error        = r_error;
        n_straight_inc = r_straight_inc;
        n_diag_inc     = r_diag_inc;
        n_minor_up     = r_minor_up;
        n_steep        = r_steep;
        n_active       = r_active;
        major_now      = '0;
        o_result       = '0;

        case (i_item.operation)
            lras_pkg::OP_LOAD: begin
                n_minor_up = (dx[lras_pkg::COORD_BITS] && dy[lras_pkg::COORD_BITS])
                          || (dx > 0 && dy > 0);
                n_steep        = !shallow;
                n_error        = lras_pkg::t_err'({min_len, 1'b0})
                               - lras_pkg::t_err'(maj_len);
                n_straight_inc = lras_pkg::t_inc'({min_len, 1'b0});
                n_diag_inc     = lras_pkg::t_err'({min_len, 1'b0})
                               - lras_pkg::t_err'({maj_len, 1'b0});
                n_cur_x = from_a ? i_item.start_x : i_item.end_x;
                n_cur_y = from_a ? i_item.start_y : i_item.end_y;
                if (shallow) begin
                    n_major_stop = from_a ? i_item.end_x : i_item.start_x;
                end else begin
                    n_major_stop = from_a ? i_item.end_y : i_item.start_y;
                end
                major_now = shallow ? n_cur_x : n_cur_y;
                n_active  = (major_now < n_major_stop);
                o_result.pixel_valid = 1'b1;
                o_result.pixel_x     = n_cur_x;
                o_result.pixel_y     = n_cur_y;
                o_result.last_pixel  = !n_active;
            end
            lras_pkg::OP_STEP: begin
                if (r_active) begin
                    if (go_straight) begin
                        n_error = r_error + lras_pkg::t_err'(r_straight_inc);
                    end else begin
                        n_error = r_error + r_diag_inc;
                        if (r_steep) begin
                            n_cur_x = r_minor_up ? r_cur_x + lras_pkg::t_coord'(1)
                                                 : r_cur_x - lras_pkg::t_coord'(1);
                        end else begin
                            n_cur_y = r_minor_up ? r_cur_y + lras_pkg::t_coord'(1)
                                                 : r_cur_y - lras_pkg::t_coord'(1);
                        end
                    end
                    if (r_steep) begin
                        n_cur_y = r_cur_y + lras_pkg::t_coord'(1);
                    end else begin
                        n_cur_x = r_cur_x + lras_pkg::t_coord'(1);
                    end
                    major_now = r_steep ? n_cur_y : n_cur_x;
                    n_active  = (major_now < r_major_stop);
                    o_result.pixel_valid = 1'b1;
                    o_result.pixel_x     = n_cur_x;
                    o_result.pixel_y     = n_cur_y;
                    o_result.last_pixel  = !n_active;
                end
            end
            default: begin
                o_result = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x        <= '0;
            r_cur_y        <= '0;
            r_major_stop   <= '0;
            r_error        <= '0;
            r_straight_inc <= '0;
            r_diag_inc     <= '0;
            r_minor_up     <= 1'b0;
            r_steep        <= 1'b0;
            r_active       <= 1'b0;
        end else if (i_accept) begin
            r_cur_x        <= n_cur_x;
            r_cur_y        <= n_cur_y;
            r_major_stop   <= n_major_stop;
            r_error        <= n_error;
            r_straight_inc <= n_straight_inc;
            r_diag_inc     <= n_diag_inc;
            r_minor_up     <= n_minor_up;
            r_steep        <= n_steep;
            r_active       <= n_active;
        end
    end

endmodule

>>> sv/lras_outbuf.sv
// Two-entry result buffer: output register plus skid register.
// Lets the walker take a new item while one result waits downstream.
// Depends on lras_pkg.
module lras_outbuf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  lras_pkg::t_out_item i_push_item,
    output logic                o_full,
    output logic                o_valid,
    input  logic                i_stall,
    output lras_pkg::t_out_item o_item
);

    logic                r_out_valid, n_out_valid;
    logic                r_skid_valid, n_skid_valid;
    lras_pkg::t_out_item r_out_item, n_out_item;
    lras_pkg::t_out_item r_skid_item, n_skid_item;
    logic                out_free;

    always_comb begin
        out_free     = !r_out_valid || !i_stall;
        n_out_valid  = r_out_valid;
        n_out_item   = r_out_item;
        n_skid_valid = r_skid_valid;
        n_skid_item  = r_skid_item;
        if (out_free) begin
            // advance: oldest item moves into the output register
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_item   = r_skid_item;
                n_skid_valid = i_push;
                n_skid_item  = i_push_item;
            end else begin
                n_out_valid = i_push;
                n_out_item  = i_push_item;
            end
        end else if (i_push) begin
            // hold the output, park the new item
            n_skid_valid = 1'b1;
            n_skid_item  = i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item  <= n_out_item;
        r_skid_item <= n_skid_item;
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

endmodule

>>> sv/line_rasterizer_unit.sv
// Bresenham line rasterizer, top level.
// Uses lras_pkg, lras_walker and lras_outbuf.
//
// Input channel (i_in_valid / o_in_stall / i_in_item): each item is either a
// load (two endpoints) or a step. A load emits the first pixel of the line;
// each step emits the next pixel, with last_pixel set on the final one. A
// step when no line is active returns an item with pixel_valid low and all
// other fields zero. A load while a line is active drops the old line.
// Output channel (o_out_valid / i_out_stall / o_out_item): one result item
// per accepted input item, in order.
// An accepted item's result enters the output register at that edge if it is
// free, else the skid register. Throughput is one item per cycle while
// o_in_stall is low; the walker's single add and compare per step set it.
// A two-entry output buffer lets one result wait while the next item is
// taken; o_in_stall is high while two results are held, which happens only
// after the receiver stalls with a result waiting, and it drops at the edge
// where the receiver takes an item. Reset (synchronous, active low) clears
// the line state and empties the output buffer.
module line_rasterizer_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lras_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lras_pkg::t_out_item o_out_item
);

    logic                accept;
    logic                buf_full;
    lras_pkg::t_out_item result;

    assign o_in_stall = buf_full;
    assign accept     = i_in_valid && !buf_full;

    lras_walker u_walker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in_item),
        .o_result (result)
    );

    lras_outbuf u_outbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept),
        .i_push_item (result),
        .o_full      (buf_full),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_item      (o_out_item)
    );

endmodule
